// ----- src/iar_pkg.sv -----
// ----------------------------------------------------------------------------
// iar_pkg
// Types and constants shared by the interrupt router modules.
// ----------------------------------------------------------------------------
`default_nettype none

package iar_pkg;

  typedef enum logic [2:0] {
    OP_REG_READ  = 3'd0,
    OP_REG_WRITE = 3'd1,
    OP_LINE_CHG  = 3'd2,
    OP_ROUTE     = 3'd3,
    OP_ACCEPT    = 3'd4,
    OP_EOI       = 3'd5
  } op_t;

  // window offsets
  localparam logic [7:0] OFF_INDEX  = 8'h00;
  localparam logic [7:0] OFF_WINDOW = 8'h10;

  // index register codes
  localparam logic [7:0] REG_ID       = 8'h00;
  localparam logic [7:0] REG_VERSION  = 8'h01;
  localparam logic [7:0] REG_ARB      = 8'h02;
  localparam logic [7:0] REG_TBL_BASE = 8'h10;

  // redirection entry bits
  localparam int ENT_MASK_BIT  = 16;
  localparam int ENT_LEVEL_BIT = 15;
  localparam int ENT_RIRR_BIT  = 14;
  localparam int ENT_DSTAT_BIT = 12;
  localparam int ENT_LOGIC_BIT = 11;

  localparam logic [63:0] ENT_RESET    = 64'h0000_0000_0001_0000;
  localparam logic [7:0]  VERSION_CODE = 8'h11;
  localparam logic [7:0]  VEC_MIN      = 8'd16;
  localparam logic [2:0]  DM_LOWEST    = 3'd1;

  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  offset;
    logic [31:0] write_data;
    logic [4:0]  line;
    logic        level_asserted;
    logic [7:0]  eoi_vector;
  } item_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] read_data;
    logic [7:0]  route_vector;
    logic [7:0]  route_destination;
    logic        route_logical;
    logic        route_level;
  } result_t;

  // state writes produced by one item
  typedef struct packed {
    logic        idx_we;
    logic [7:0]  idx_val;
    logic        ent_we;
    logic [63:0] ent_val;
    logic        acc_we;
    logic [7:0]  acc_val;
  } upd_t;

  // table entry number addressed by an index register value
  function automatic logic [6:0] win_entry(input logic [7:0] idx);
    logic [7:0] d;
    d = idx - REG_TBL_BASE;
    return d[7:1];
  endfunction

endpackage

`default_nettype wire

// ----- src/iar_in_if.sv -----
// ----------------------------------------------------------------------------
// iar_in_if
// Item channel: valid/ready handshake with the request fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface iar_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [7:0]  offset;
  logic [31:0] write_data;
  logic [4:0]  line;
  logic        level_asserted;
  logic [7:0]  eoi_vector;

  modport source (
    output valid, op, offset, write_data, line, level_asserted, eoi_vector,
    input  ready
  );
  modport sink (
    input  valid, op, offset, write_data, line, level_asserted, eoi_vector,
    output ready
  );
endinterface

`default_nettype wire

// ----- src/iar_out_if.sv -----
// ----------------------------------------------------------------------------
// iar_out_if
// Result channel: valid/ready handshake with the response fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface iar_out_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [31:0] read_data;
  logic [7:0]  route_vector;
  logic [7:0]  route_destination;
  logic        route_logical;
  logic        route_level;

  modport source (
    output valid, ok, read_data, route_vector, route_destination, route_logical,
           route_level,
    input  ready
  );
  modport sink (
    input  valid, ok, read_data, route_vector, route_destination, route_logical,
           route_level,
    output ready
  );
endinterface

`default_nettype wire

// ----- src/iar_ram.sv -----
// ----------------------------------------------------------------------------
// iar_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module iar_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 24,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [AW-1:0]            waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [AW-1:0]            raddr,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- src/iar_exec.sv -----
// ----------------------------------------------------------------------------
// iar_exec
// Evaluates one item against its redirection entry and the line bit sets.
// ----------------------------------------------------------------------------
`default_nettype none

module iar_exec
  import iar_pkg::*;
#(
  parameter int LINE_COUNT = 24
) (
  input  wire item_t                  item,
  input  wire logic [63:0]            ent,
  input  wire logic [7:0]             idx,
  input  wire logic [3:0]             apic_id,
  input  wire logic [LINE_COUNT-1:0]  asrt,
  input  wire logic [LINE_COUNT-1:0]  pend,
  input  wire logic [LINE_COUNT-1:0]  rirr,
  input  wire logic [7:0]             acc_vec [LINE_COUNT],
  output      result_t                res,
  output      upd_t                   upd,
  output      logic [LINE_COUNT-1:0]  asrt_nxt,
  output      logic [LINE_COUNT-1:0]  pend_nxt,
  output      logic [LINE_COUNT-1:0]  rirr_nxt
);
  localparam int LINE_W = (LINE_COUNT > 1) ? $clog2(LINE_COUNT) : 1;
  localparam logic [8:0] TBL_END = 9'(16 + 2 * LINE_COUNT);
  localparam logic [5:0] LINE_LIM = 6'(LINE_COUNT);

  logic [LINE_W-1:0]     win_n;
  logic [LINE_COUNT-1:0] win_m;
  logic [LINE_COUNT-1:0] line_m;
  logic                  tbl_hit;
  logic                  line_ok;
  logic                  wr;
  logic                  route_ok;
  logic [63:0]           rb;
  logic [31:0]           d;
  logic [31:0]           id_val;

  assign win_n   = LINE_W'(win_entry(idx));
  assign win_m   = LINE_COUNT'(1) << win_n;
  assign line_m  = LINE_COUNT'(1) << LINE_W'(item.line);
  assign tbl_hit = (idx >= REG_TBL_BASE) && ({1'b0, idx} < TBL_END);
  assign line_ok = {1'b0, item.line} < LINE_LIM;
  assign wr      = (item.op == OP_REG_WRITE);
  assign id_val  = {4'd0, apic_id, 24'd0};

  assign route_ok = line_ok && !ent[ENT_MASK_BIT] && !(|(rirr & line_m)) &&
                    (ent[7:0] >= VEC_MIN) &&
                    (ent[ENT_LEVEL_BIT] ? |(asrt & line_m) : |(pend & line_m));

  always_comb begin
    res      = '0;
    upd      = '0;
    asrt_nxt = asrt;
    pend_nxt = pend;
    rirr_nxt = rirr;
    rb       = ent | (|(rirr & win_m) ? (64'd1 << ENT_RIRR_BIT) : 64'd0);
    d        = item.write_data;

    case (op_t'(item.op))
      OP_REG_READ, OP_REG_WRITE: begin
        if (item.offset == OFF_INDEX) begin
          if (wr) begin
            if (item.write_data[31:8] == 24'd0) begin
              res.ok      = 1'b1;
              upd.idx_we  = 1'b1;
              upd.idx_val = item.write_data[7:0];
            end
          end else begin
            res.ok        = 1'b1;
            res.read_data = {24'd0, idx};
          end
        end else if (item.offset == OFF_WINDOW) begin
          if (idx == REG_ID || idx == REG_ARB) begin
            if (wr) begin
              res.ok = (idx == REG_ID) && (item.write_data == id_val);
            end else begin
              res.ok        = 1'b1;
              res.read_data = id_val;
            end
          end else if (idx == REG_VERSION) begin
            if (!wr) begin
              res.ok        = 1'b1;
              res.read_data = {8'd0, 8'(LINE_COUNT - 1), 8'd0, VERSION_CODE};
            end
          end else if (tbl_hit) begin
            if (!wr) begin
              res.ok        = 1'b1;
              res.read_data = idx[0] ? rb[63:32] : rb[31:0];
            end else if (idx[0]) begin
              if (d[23:0] == 24'd0) begin
                res.ok      = 1'b1;
                upd.ent_we  = 1'b1;
                upd.ent_val = {d, ent[31:0]};
              end
            end else begin
              // read-only status bits are dropped before the checks
              d[ENT_DSTAT_BIT] = 1'b0;
              d[ENT_RIRR_BIT]  = 1'b0;
              if (d[31:17] == 15'd0 && d[10:8] <= DM_LOWEST &&
                  (d[ENT_MASK_BIT] || d[7:0] >= VEC_MIN)) begin
                res.ok      = 1'b1;
                upd.ent_we  = 1'b1;
                upd.ent_val = {ent[63:32], d};
              end
            end
          end
        end
        if (!res.ok || wr) begin
          res.read_data = '0;
        end
      end
      OP_LINE_CHG: begin
        if (line_ok) begin
          res.ok = 1'b1;
          if (item.level_asserted) begin
            // rising edge of an unmasked edge line
            if (!(|(asrt & line_m)) && !ent[ENT_MASK_BIT] && !ent[ENT_LEVEL_BIT]) begin
              pend_nxt = pend | line_m;
            end
            asrt_nxt = asrt | line_m;
          end else begin
            asrt_nxt = asrt & ~line_m;
          end
        end
      end
      OP_ROUTE, OP_ACCEPT: begin
        if (route_ok) begin
          res.ok                = 1'b1;
          res.route_vector      = ent[7:0];
          res.route_destination = ent[63:56];
          res.route_logical     = ent[ENT_LOGIC_BIT];
          res.route_level       = ent[ENT_LEVEL_BIT];
          if (op_t'(item.op) == OP_ACCEPT) begin
            pend_nxt = pend & ~line_m;
            if (ent[ENT_LEVEL_BIT]) begin
              rirr_nxt    = rirr | line_m;
              upd.acc_we  = 1'b1;
              upd.acc_val = ent[7:0];
            end
          end
        end
      end
      OP_EOI: begin
        res.ok = 1'b1;
        if (item.eoi_vector >= VEC_MIN) begin
          for (int i = 0; i < LINE_COUNT; i++) begin
            rirr_nxt[i] = rirr[i] & (acc_vec[i] != item.eoi_vector);
          end
        end
      end
      default: begin
        res.ok = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- src/ioapic_interrupt_router_unit.sv -----
// ----------------------------------------------------------------------------
// ioapic_interrupt_router_unit
// I/O interrupt controller: index/window registers, per-line redirection
// entries in a table memory, line, route, accept and end-of-interrupt items.
// ----------------------------------------------------------------------------
// result: the result register loads when ST_EXEC commits, after ST_IDLE takes the
//   input beat; the commit waits while the previous result waits to be drained
// items: a new item is taken only back in ST_IDLE, set by the read-then-write of
//   the redirection table memory (a read step, then an execute/write-back step)
// reset: control, index, id and line bit sets clear at once; the table reads
//   as masked through per-entry written flags, so there is no clearing pass
`default_nettype none

module ioapic_interrupt_router_unit
  import iar_pkg::*;
#(
  parameter int LINE_COUNT = 24
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  iar_in_if.sink     in_chan,
  iar_out_if.source  out_chan,
  input  wire logic        cfg_we,
  input  wire logic [3:0]  cfg_wdata
);
  localparam int LINE_W = (LINE_COUNT > 1) ? $clog2(LINE_COUNT) : 1;

  typedef enum logic {ST_IDLE, ST_EXEC} state_t;

  state_t                state_r;
  item_t                 item_r;
  logic [LINE_W-1:0]     addr_r;
  logic                  ent_vld_r;
  logic [7:0]            idx_r;
  logic [3:0]            apic_id_r;
  logic [LINE_COUNT-1:0] written_r;
  logic [LINE_COUNT-1:0] asrt_r, pend_r, rirr_r;
  logic [7:0]            acc_vec_r [LINE_COUNT];
  logic                  out_valid_r;
  result_t               out_res_r;

  item_t                 in_item;
  logic                  in_beat;
  logic [LINE_W-1:0]     rd_addr;
  logic [63:0]           ram_q;
  logic [63:0]           ent;
  logic                  commit;
  result_t               res;
  upd_t                  upd;
  logic [LINE_COUNT-1:0] asrt_nxt, pend_nxt, rirr_nxt;

  assign in_item.op             = in_chan.op;
  assign in_item.offset         = in_chan.offset;
  assign in_item.write_data     = in_chan.write_data;
  assign in_item.line           = in_chan.line;
  assign in_item.level_asserted = in_chan.level_asserted;
  assign in_item.eoi_vector     = in_chan.eoi_vector;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_beat       = in_chan.valid && in_chan.ready;

  // register accesses address the entry picked by the index register
  assign rd_addr = (in_chan.op == OP_REG_READ || in_chan.op == OP_REG_WRITE) ?
                   LINE_W'(win_entry(idx_r)) : LINE_W'(in_chan.line);

  iar_ram #(
    .WIDTH (64),
    .DEPTH (LINE_COUNT)
  ) u_tbl (
    .clk   (clk),
    .we    (commit && upd.ent_we),
    .waddr (addr_r),
    .wdata (upd.ent_val),
    .re    (in_beat),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  assign ent = ent_vld_r ? ram_q : ENT_RESET;

  iar_exec #(
    .LINE_COUNT (LINE_COUNT)
  ) u_exec (
    .item     (item_r),
    .ent      (ent),
    .idx      (idx_r),
    .apic_id  (apic_id_r),
    .asrt     (asrt_r),
    .pend     (pend_r),
    .rirr     (rirr_r),
    .acc_vec  (acc_vec_r),
    .res      (res),
    .upd      (upd),
    .asrt_nxt (asrt_nxt),
    .pend_nxt (pend_nxt),
    .rirr_nxt (rirr_nxt)
  );

  // finish only when the result register is free or being drained
  assign commit = (state_r == ST_EXEC) && (!out_valid_r || out_chan.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      apic_id_r   <= '0;
      written_r   <= '0;
      asrt_r      <= '0;
      pend_r      <= '0;
      rirr_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        apic_id_r <= cfg_wdata;
      end
      if (out_valid_r && out_chan.ready && !commit) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_beat) begin
            state_r <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (commit) begin
            state_r     <= ST_IDLE;
            out_valid_r <= 1'b1;
            asrt_r      <= asrt_nxt;
            pend_r      <= pend_nxt;
            rirr_r      <= rirr_nxt;
            if (upd.idx_we) begin
              idx_r <= upd.idx_val;
            end
            if (upd.ent_we) begin
              written_r <= written_r | (LINE_COUNT'(1) << addr_r);
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_beat) begin
      item_r    <= in_item;
      addr_r    <= rd_addr;
      ent_vld_r <= |(written_r & (LINE_COUNT'(1) << rd_addr));
    end
    if (commit) begin
      out_res_r <= res;
      if (upd.acc_we) begin
        acc_vec_r[addr_r] <= upd.acc_val;
      end
    end
  end

  assign out_chan.valid             = out_valid_r;
  assign out_chan.ok                = out_res_r.ok;
  assign out_chan.read_data         = out_res_r.read_data;
  assign out_chan.route_vector      = out_res_r.route_vector;
  assign out_chan.route_destination = out_res_r.route_destination;
  assign out_chan.route_logical     = out_res_r.route_logical;
  assign out_chan.route_level       = out_res_r.route_level;

endmodule

`default_nettype wire
